>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the key detector.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: consequent does not hold");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: consequent does not hold one cycle later");

`endif

>>> sv/kcd_pkg.sv
// Types, codes and helper functions of the key click/double/long detector.
// No dependencies.
package kcd_pkg;

   typedef enum logic [1:0] {
      MODE_CLASSIFY = 2'd0,
      MODE_SINGLE   = 2'd1,
      MODE_COMBO    = 2'd2,
      MODE_IDLE     = 2'd3
   } scan_mode_type;

   typedef enum logic [1:0] {
      PH_WAIT     = 2'd0,
      PH_PRESSED  = 2'd1,
      PH_LONG     = 2'd2,
      PH_RELEASED = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_CLICK  = 3'd1,
      EV_DOUBLE = 3'd2,
      EV_LONG   = 3'd3,
      EV_COMBO  = 3'd4
   } event_type;

   // Control group from the scan sequencer to the press phase machine.
   typedef struct packed {
      logic step;   // run one step of the phase machine
      logic clear;  // return to waiting for a press
      logic down;   // raw level of the chosen key
   } phase_ctrl_type;

   localparam int unsigned KEY_BITS = 8;
   localparam int unsigned CNT_BITS = 16;

   localparam logic [1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [1:0] CSR_LONG     = 2'd1;
   localparam logic [1:0] CSR_DOUBLE   = 2'd2;

   localparam logic [CNT_BITS-1:0] DEBOUNCE_RESET = 16'd5;
   localparam logic [CNT_BITS-1:0] LONG_RESET     = 16'd100;
   localparam logic [CNT_BITS-1:0] DOUBLE_RESET   = 16'd30;

   localparam logic [KEY_BITS-1:0] PINS_KEYS_01 = 8'd3;
   localparam logic [KEY_BITS-1:0] PINS_KEYS_02 = 8'd5;
   localparam logic [KEY_BITS-1:0] PINS_KEYS_12 = 8'd6;

   localparam logic [1:0] COMBO_OTHER   = 2'd0;
   localparam logic [1:0] COMBO_KEYS_01 = 2'd1;
   localparam logic [1:0] COMBO_KEYS_02 = 2'd2;
   localparam logic [1:0] COMBO_KEYS_12 = 2'd3;

   // Index of the lowest set bit, zero when no bit is set.
   function automatic logic [2:0] lowest_key(input logic [KEY_BITS-1:0] pins);
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
         if (pins[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

   // True when exactly one bit is set.
   function automatic logic single_key(input logic [KEY_BITS-1:0] pins);
      return (pins != '0) && ((pins & (pins - 8'd1)) == '0);
   endfunction

   // 16-bit counter step that stops at all ones.
   function automatic logic [CNT_BITS-1:0] sat16(input logic [CNT_BITS:0] v);
      return v[CNT_BITS] ? {CNT_BITS{1'b1}} : v[CNT_BITS-1:0];
   endfunction

endpackage

>>> sv/kcd_phase.sv
// Press phase machine of the key detector: held and release counters and
// the click, double click and long press decisions. Depends on kcd_pkg.
module kcd_phase
   import kcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  phase_ctrl_type      ctrl,
   input  logic [CNT_BITS-1:0] debounce_ticks,
   input  logic [CNT_BITS-1:0] long_ticks,
   input  logic [CNT_BITS-1:0] double_ticks,
   output event_type           phase_event
);

   phase_type           phase_ff, phase_in;
   logic [CNT_BITS-1:0] held_ff, held_in;
   logic [CNT_BITS-1:0] release_ff, release_in;

   logic [CNT_BITS:0] held_inc;
   logic [CNT_BITS:0] release_inc;
   logic              rel_done;
   logic              long_done;
   logic              dbl_hit;
   logic              wait_done;

   // Compares use the incremented value before saturation.
   assign held_inc    = {1'b0, held_ff} + 17'd1;
   assign release_inc = {1'b0, release_ff} + 17'd1;
   assign rel_done    = release_inc > {1'b0, debounce_ticks};
   assign long_done   = held_inc > {1'b0, long_ticks};
   assign dbl_hit     = held_inc == {1'b0, debounce_ticks};
   assign wait_done   = release_inc > {1'b0, double_ticks};

   always_comb begin
      phase_in = phase_ff;
      if (ctrl.clear) begin
         phase_in = PH_WAIT;
      end else if (ctrl.step) begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (ctrl.down) phase_in = PH_PRESSED;
            end
            PH_PRESSED: begin
               if (!ctrl.down && rel_done) phase_in = PH_RELEASED;
               else if (ctrl.down && long_done) phase_in = PH_LONG;
            end
            PH_LONG: begin
               if (!ctrl.down) phase_in = PH_WAIT;
            end
            PH_RELEASED: begin
               if (ctrl.down ? dbl_hit : wait_done) phase_in = PH_WAIT;
            end
         endcase
      end
   end

   always_comb begin
      held_in     = held_ff;
      release_in  = release_ff;
      phase_event = EV_NONE;
      if (ctrl.step) begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (ctrl.down) begin
                  held_in    = '0;
                  release_in = '0;
               end
            end
            PH_PRESSED: begin
               if (!ctrl.down) begin
                  release_in = rel_done ? '0 : sat16(release_inc);
                  if (rel_done) held_in = '0;
               end else begin
                  held_in = sat16(held_inc);
                  if (long_done) release_in = '0;
               end
            end
            PH_LONG: begin
               if (!ctrl.down) phase_event = EV_LONG;
            end
            PH_RELEASED: begin
               if (ctrl.down) begin
                  held_in = sat16(held_inc);
                  if (dbl_hit) phase_event = EV_DOUBLE;
               end else begin
                  release_in = sat16(release_inc);
                  if (wait_done) begin
                     held_in     = '0;
                     phase_event = EV_CLICK;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT;
         held_ff    <= '0;
         release_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         release_ff <= release_in;
      end
   end

endmodule

>>> sv/key_click_double_long_detector.sv
// A scan tick is captured in the input stage and its result beat is registered in the result stage.
// One tick per cycle while the consumer takes results; the input and result stages each hold one beat.
// The state feedback (debounce, scan mode, press phase) is updated with each tick, so the next tick sees it.
// Reset is synchronous and active high: it clears state and restores registers.
// Depends on kcd_pkg and kcd_phase.
module key_click_double_long_detector
   import kcd_pkg::*;
#(
   parameter int unsigned NUM_KEYS = 8
)
(
   input  logic                clock,
   input  logic                reset,
   // Scan tick input channel.
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KEY_BITS-1:0] req_pressed_keys,
   // Result channel, one beat per scan tick.
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_event_res,
   output logic [2:0]          rsp_key_index,
   output logic [1:0]          rsp_combo_code,
   // Register write channel.
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [CNT_BITS-1:0] csr_wdata
);

   // Keys at or above NUM_KEYS are ignored.
   localparam logic [KEY_BITS-1:0] KeyMask = (NUM_KEYS >= KEY_BITS) ? {KEY_BITS{1'b1}} :
      KEY_BITS'((16'd1 << NUM_KEYS) - 16'd1);

   // Configuration registers. Writes are always taken.
   logic [CNT_BITS-1:0] debounce_ff;
   logic [CNT_BITS-1:0] long_ff;
   logic [CNT_BITS-1:0] double_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         long_ff     <= LONG_RESET;
         double_ff   <= DOUBLE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_wdata;
            CSR_LONG:     long_ff     <= csr_wdata;
            CSR_DOUBLE:   double_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input stage. It takes a new beat when empty or when its beat moves on,
   // so while a result waits on the output it still captures one tick, but
   // then stops taking ticks until that result is taken.
   logic                in_valid_ff;
   logic [KEY_BITS-1:0] in_pins_ff;
   logic                out_free;
   logic                fire;

   assign out_free  = !rsp_valid || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pins_ff <= '0;
      end else if (req_valid && req_ready) begin
         in_pins_ff <= req_pressed_keys;
      end
   end

   // Debounce: the masked vector must stay unchanged for debounce_ticks
   // ticks. The stable count saturates, and while it rests on a value equal
   // to debounce_ticks the vector is accepted again every tick.
   logic [KEY_BITS-1:0] cur_pins;
   logic [KEY_BITS-1:0] stable_pins_ff;
   logic [CNT_BITS-1:0] stable_count_ff, stable_count_in;
   logic                accept;

   assign cur_pins        = in_pins_ff & KeyMask;
   assign stable_count_in = (cur_pins == stable_pins_ff) ?
                            sat16({1'b0, stable_count_ff} + 17'd1) : '0;
   assign accept          = (stable_count_in == debounce_ff) && (cur_pins != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_pins_ff  <= '0;
         stable_count_ff <= '0;
      end else if (fire) begin
         stable_pins_ff  <= cur_pins;
         stable_count_ff <= stable_count_in;
      end
   end

   // Scan sequencer. An acceptance forces classify mode, which overrides a
   // combo that has not been reported yet. Classify picks the lowest key and
   // goes to single mode for one key or combo mode for several; combo mode
   // reports on the next tick and goes idle.
   scan_mode_type  scan_mode_ff, scan_mode_in;
   scan_mode_type  mode_now;
   logic [2:0]     chosen_key_ff, chosen_key_in;
   phase_ctrl_type phase_ctrl;
   event_type      phase_event;
   event_type      event_in;
   logic [2:0]     key_index_in;
   logic [1:0]     combo_code_in;

   assign mode_now = accept ? MODE_CLASSIFY : scan_mode_ff;

   always_comb begin
      scan_mode_in = scan_mode_ff;
      if (fire) begin
         unique case (mode_now)
            MODE_COMBO: scan_mode_in = MODE_IDLE;
            MODE_CLASSIFY: begin
               if (single_key(cur_pins)) scan_mode_in = MODE_SINGLE;
               else if (cur_pins != '0) scan_mode_in = MODE_COMBO;
               else scan_mode_in = MODE_CLASSIFY;
            end
            MODE_SINGLE: begin
               if (phase_event != EV_NONE) scan_mode_in = MODE_IDLE;
               else scan_mode_in = MODE_SINGLE;
            end
            MODE_IDLE: scan_mode_in = MODE_IDLE;
         endcase
      end
   end

   always_comb begin
      chosen_key_in    = chosen_key_ff;
      phase_ctrl.step  = fire && (mode_now == MODE_SINGLE);
      phase_ctrl.clear = fire && (mode_now == MODE_COMBO);
      phase_ctrl.down  = cur_pins[chosen_key_ff];
      event_in         = EV_NONE;
      key_index_in     = 3'd0;
      combo_code_in    = COMBO_OTHER;
      unique case (mode_now)
         MODE_COMBO: begin
            event_in = EV_COMBO;
            priority if (cur_pins == PINS_KEYS_01) combo_code_in = COMBO_KEYS_01;
            else if (cur_pins == PINS_KEYS_02) combo_code_in = COMBO_KEYS_02;
            else if (cur_pins == PINS_KEYS_12) combo_code_in = COMBO_KEYS_12;
            else combo_code_in = COMBO_OTHER;
         end
         MODE_CLASSIFY: begin
            if (fire) chosen_key_in = lowest_key(cur_pins);
         end
         MODE_SINGLE: begin
            event_in = phase_event;
            if (phase_event != EV_NONE) key_index_in = chosen_key_ff;
         end
         MODE_IDLE: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_mode_ff  <= MODE_IDLE;
         chosen_key_ff <= 3'd0;
      end else begin
         scan_mode_ff  <= scan_mode_in;
         chosen_key_ff <= chosen_key_in;
      end
   end

   kcd_phase u_phase (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (phase_ctrl),
      .debounce_ticks (debounce_ff),
      .long_ticks     (long_ff),
      .double_ticks   (double_ff),
      .phase_event    (phase_event)
   );

   // Result stage: one beat per tick, held until the consumer takes it.
   logic       rsp_valid_ff;
   logic [2:0] rsp_event_ff;
   logic [2:0] rsp_key_index_ff;
   logic [1:0] rsp_combo_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_event_ff      <= event_in;
         rsp_key_index_ff  <= key_index_in;
         rsp_combo_code_ff <= combo_code_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_res  = rsp_event_ff;
   assign rsp_key_index  = rsp_key_index_ff;
   assign rsp_combo_code = rsp_combo_code_ff;

endmodule

>>> sv/kcd_checker.sv
// Port-level checks of the key detector, attached to the top level by bind.
// Depends on kcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kcd_checker
   import kcd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [2:0]          rsp_event_res,
   input logic [2:0]          rsp_key_index,
   input logic [1:0]          rsp_combo_code
);

   logic stalled;
   logic rsp_keyless;

   assign stalled     = rsp_valid && !rsp_ready;
   assign rsp_keyless = (rsp_event_res == EV_NONE) || (rsp_event_res == EV_COMBO);

   // A stalled result beat stays and keeps its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, stalled,
      rsp_valid && $stable(rsp_event_res) && $stable(rsp_key_index) && $stable(rsp_combo_code))

   // Combo code only travels with a combo event.
   `ASSERT_IMPLIES(a_combo_only, clock, reset,
      rsp_valid && (rsp_event_res != EV_COMBO), rsp_combo_code == COMBO_OTHER)

   // Events without a single key carry key index zero.
   `ASSERT_IMPLIES(a_keyless_index, clock, reset, rsp_valid && rsp_keyless, rsp_key_index == 3'd0)

   // No result beat right after reset.
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind key_click_double_long_detector kcd_checker u_kcd_checker (.*);
